[src/bufuart_pkg.sv]
// Shared widths, request and status codes, and control structs for the buffered UART channel.
`default_nettype none

package bufuart_pkg;

   localparam int DATA_W   = 8;
   localparam int TYPE_W   = 3;
   localparam int STATUS_W = 3;

   localparam int TX_DEPTH_DEFAULT = 64;
   localparam int RX_DEPTH_DEFAULT = 64;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_SW_WRITE    = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_SW_READ     = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_LINE_RX     = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_LINE_READY  = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_TX_COMPLETE = 3'd4;
   localparam logic [TYPE_W-1:0] REQ_STATUS      = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TX_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RX_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DISCARD     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RX_OVERFLOW = 3'd4;

   // controller -> datapath
   typedef struct packed {
      logic accept;      // perform the step for the request on the bus
      logic load_now;    // load result register from the step just taken
      logic load_fetch;  // load result register from the buffer read data
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_fetch; // request on the bus reads a FIFO buffer
   } ctrl_stat_type;

endpackage

`default_nettype wire

[src/bufuart_if.sv]
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface bufuart_req_if;
   logic                         valid;
   logic                         ready;
   logic [bufuart_pkg::TYPE_W-1:0] req_type;
   logic [bufuart_pkg::DATA_W-1:0] tx_byte;
   logic [bufuart_pkg::DATA_W-1:0] line_byte;
   logic                         framing_error;
   logic                         parity_error;

   modport source (output valid, req_type, tx_byte, line_byte, framing_error, parity_error,
                   input ready);
   modport sink   (input valid, req_type, tx_byte, line_byte, framing_error, parity_error,
                   output ready);
endinterface

interface bufuart_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bufuart_pkg::STATUS_W-1:0] status;
   logic [bufuart_pkg::DATA_W-1:0]   read_byte;
   logic                           send_valid;
   logic [bufuart_pkg::DATA_W-1:0]   send_byte;
   logic                           tx_full;
   logic                           tx_empty;
   logic                           rx_empty;
   logic                           write_done;

   modport source (output valid, status, read_byte, send_valid, send_byte, tx_full, tx_empty,
                   rx_empty, write_done, input ready);
   modport sink   (input valid, status, read_byte, send_valid, send_byte, tx_full, tx_empty,
                   rx_empty, write_done, output ready);
endinterface

`default_nettype wire

[src/bufuart_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bufuart_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[src/bufuart_dp.sv]
// Datapath: FIFO buffers, pointers, fill counts, arming flags and the result register.
`default_nettype none

module bufuart_dp #(
   parameter int TX_DEPTH = bufuart_pkg::TX_DEPTH_DEFAULT,
   parameter int RX_DEPTH = bufuart_pkg::RX_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [bufuart_pkg::TYPE_W-1:0]    req_type,
   input  wire logic [bufuart_pkg::DATA_W-1:0]    tx_byte,
   input  wire logic [bufuart_pkg::DATA_W-1:0]    line_byte,
   input  wire logic                              framing_error,
   input  wire logic                              parity_error,
   input  wire bufuart_pkg::ctrl_cmd_type         cmd,
   output      bufuart_pkg::ctrl_stat_type        stat,
   output      logic [bufuart_pkg::STATUS_W-1:0]  status,
   output      logic [bufuart_pkg::DATA_W-1:0]    read_byte,
   output      logic                              send_valid,
   output      logic [bufuart_pkg::DATA_W-1:0]    send_byte,
   output      logic                              tx_full,
   output      logic                              tx_empty,
   output      logic                              rx_empty,
   output      logic                              write_done
);

   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int TX_CW = $clog2(TX_DEPTH + 1);
   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int DW    = bufuart_pkg::DATA_W;

   logic [TX_AW-1:0] tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [TX_CW-1:0] tx_count_ff, tx_count_in;
   logic [RX_AW-1:0] rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [RX_CW-1:0] rx_count_ff, rx_count_in;
   logic             done_ff, done_in;
   logic             ready_armed_ff, ready_armed_in;
   logic             complete_armed_ff, complete_armed_in;
   logic             fetch_rx_ff, fetch_rx_in;

   logic [bufuart_pkg::STATUS_W-1:0] step_status;
   logic tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
   logic [DW-1:0] tx_rd_data, rx_rd_data;
   logic tx_is_full, tx_is_empty, rx_is_full, rx_is_empty;

   logic [bufuart_pkg::STATUS_W-1:0] status_ff;
   logic [DW-1:0] read_byte_ff, send_byte_ff;
   logic send_valid_ff, tx_full_ff, tx_empty_ff, rx_empty_ff, write_done_ff;

   assign tx_is_full  = (tx_count_ff == TX_CW'(TX_DEPTH));
   assign tx_is_empty = (tx_count_ff == '0);
   assign rx_is_full  = (rx_count_ff == RX_CW'(RX_DEPTH));
   assign rx_is_empty = (rx_count_ff == '0);

   assign stat.needs_fetch =
      ((req_type == bufuart_pkg::REQ_SW_READ) && !rx_is_empty) ||
      ((req_type == bufuart_pkg::REQ_LINE_READY) && ready_armed_ff && !tx_is_empty);

   always_comb begin
      tx_head_in        = tx_head_ff;
      tx_tail_in        = tx_tail_ff;
      tx_count_in       = tx_count_ff;
      rx_head_in        = rx_head_ff;
      rx_tail_in        = rx_tail_ff;
      rx_count_in       = rx_count_ff;
      done_in           = done_ff;
      ready_armed_in    = ready_armed_ff;
      complete_armed_in = complete_armed_ff;
      fetch_rx_in       = fetch_rx_ff;
      step_status       = bufuart_pkg::ST_OK;
      tx_wr_en          = 1'b0;
      tx_rd_en          = 1'b0;
      rx_wr_en          = 1'b0;
      rx_rd_en          = 1'b0;
      if (cmd.accept) begin
         case (req_type)
            bufuart_pkg::REQ_SW_WRITE: begin
               if (tx_is_full) begin
                  step_status = bufuart_pkg::ST_TX_FULL;
               end else begin
                  tx_wr_en       = 1'b1;
                  tx_head_in     = (tx_head_ff == TX_AW'(TX_DEPTH - 1)) ? '0
                                   : tx_head_ff + TX_AW'(1);
                  tx_count_in    = tx_count_ff + TX_CW'(1);
                  ready_armed_in = 1'b1;
               end
            end
            bufuart_pkg::REQ_SW_READ: begin
               if (rx_is_empty) begin
                  step_status = bufuart_pkg::ST_RX_EMPTY;
               end else begin
                  rx_rd_en    = 1'b1;
                  fetch_rx_in = 1'b1;
                  rx_tail_in  = (rx_tail_ff == RX_AW'(RX_DEPTH - 1)) ? '0
                                : rx_tail_ff + RX_AW'(1);
                  rx_count_in = rx_count_ff - RX_CW'(1);
               end
            end
            bufuart_pkg::REQ_LINE_RX: begin
               // error check wins over the overflow check
               if (framing_error || parity_error) begin
                  step_status = bufuart_pkg::ST_DISCARD;
               end else if (rx_is_full) begin
                  step_status = bufuart_pkg::ST_RX_OVERFLOW;
               end else begin
                  rx_wr_en    = 1'b1;
                  rx_head_in  = (rx_head_ff == RX_AW'(RX_DEPTH - 1)) ? '0
                                : rx_head_ff + RX_AW'(1);
                  rx_count_in = rx_count_ff + RX_CW'(1);
               end
            end
            bufuart_pkg::REQ_LINE_READY: begin
               if (ready_armed_ff) begin
                  if (tx_is_empty) begin
                     ready_armed_in    = 1'b0;
                     complete_armed_in = 1'b1;
                  end else begin
                     tx_rd_en    = 1'b1;
                     fetch_rx_in = 1'b0;
                     tx_tail_in  = (tx_tail_ff == TX_AW'(TX_DEPTH - 1)) ? '0
                                   : tx_tail_ff + TX_AW'(1);
                     tx_count_in = tx_count_ff - TX_CW'(1);
                     done_in     = 1'b0;
                  end
               end
            end
            bufuart_pkg::REQ_TX_COMPLETE: begin
               if (complete_armed_ff) begin
                  done_in           = 1'b1;
                  complete_armed_in = 1'b0;
               end
            end
            default: begin
               // status query and unused codes: no state change
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff        <= '0;
         tx_tail_ff        <= '0;
         tx_count_ff       <= '0;
         rx_head_ff        <= '0;
         rx_tail_ff        <= '0;
         rx_count_ff       <= '0;
         done_ff           <= 1'b1;
         ready_armed_ff    <= 1'b0;
         complete_armed_ff <= 1'b0;
      end else begin
         tx_head_ff        <= tx_head_in;
         tx_tail_ff        <= tx_tail_in;
         tx_count_ff       <= tx_count_in;
         rx_head_ff        <= rx_head_in;
         rx_tail_ff        <= rx_tail_in;
         rx_count_ff       <= rx_count_in;
         done_ff           <= done_in;
         ready_armed_ff    <= ready_armed_in;
         complete_armed_ff <= complete_armed_in;
      end
   end

   // result register; flags reflect state after the step
   always_ff @(posedge clock) begin
      fetch_rx_ff <= fetch_rx_in;
      if (cmd.load_now) begin
         status_ff     <= step_status;
         read_byte_ff  <= '0;
         send_valid_ff <= 1'b0;
         send_byte_ff  <= '0;
      end else if (cmd.load_fetch) begin
         status_ff     <= bufuart_pkg::ST_OK;
         read_byte_ff  <= fetch_rx_ff ? rx_rd_data : '0;
         send_valid_ff <= !fetch_rx_ff;
         send_byte_ff  <= fetch_rx_ff ? '0 : tx_rd_data;
      end
      if (cmd.load_now || cmd.load_fetch) begin
         tx_full_ff    <= (tx_count_in == TX_CW'(TX_DEPTH));
         tx_empty_ff   <= (tx_count_in == '0);
         rx_empty_ff   <= (rx_count_in == '0);
         write_done_ff <= (tx_count_in == '0) && done_in;
      end
   end

   bufuart_ram #(.WIDTH(DW), .DEPTH(TX_DEPTH)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_head_ff),
      .wr_data (tx_byte),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_tail_ff),
      .rd_data (tx_rd_data)
   );

   bufuart_ram #(.WIDTH(DW), .DEPTH(RX_DEPTH)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_head_ff),
      .wr_data (line_byte),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_tail_ff),
      .rd_data (rx_rd_data)
   );

   assign status     = status_ff;
   assign read_byte  = read_byte_ff;
   assign send_valid = send_valid_ff;
   assign send_byte  = send_byte_ff;
   assign tx_full    = tx_full_ff;
   assign tx_empty   = tx_empty_ff;
   assign rx_empty   = rx_empty_ff;
   assign write_done = write_done_ff;

endmodule

`default_nettype wire

[src/bufuart_ctrl.sv]
// Controller: request/response handshake sequencing and buffer-read wait state.
`default_nettype none

module bufuart_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   input  wire bufuart_pkg::ctrl_stat_type stat,
   output      bufuart_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_FETCH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // result register can take a new result this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.accept     = 1'b0;
      cmd.load_now   = 1'b0;
      cmd.load_fetch = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready  = slot_free;
            cmd.accept = req_valid && slot_free;
            if (cmd.accept) begin
               if (stat.needs_fetch) begin
                  state_in = S_FETCH;
               end else begin
                  cmd.load_now = 1'b1;
               end
            end
         end
         S_FETCH: begin
            cmd.load_fetch = slot_free;
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (cmd.load_now || cmd.load_fetch) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[src/buffered_uart_channel.sv]
// Top level of the buffered UART channel: controller plus FIFO datapath.
`default_nettype none

// Byte channel between software and a serial line, with a TX_DEPTH-byte transmit FIFO
// and an RX_DEPTH-byte receive FIFO (any depth of 2 or more, full depth usable). Each
// request transfer yields exactly one response transfer carrying a status code, any byte
// read or handed to the line transmitter, and the FIFO/done flags as they stand after the
// request. Requests that read no buffer (writes, line bytes, empty reads, idle line-ready,
// tx complete, status) load the result straight from S_IDLE; a software read that pops a
// byte and a line-ready that sends one pass through S_FETCH first, because the FIFO RAMs
// have a registered read port. The result sits in an output register, so the next request
// is taken in the same cycle the pending response transfer completes. No clearing pass:
// buffer contents are only read after being written, tracked by the fill counts.
module buffered_uart_channel #(
   parameter int TX_DEPTH = bufuart_pkg::TX_DEPTH_DEFAULT,
   parameter int RX_DEPTH = bufuart_pkg::RX_DEPTH_DEFAULT
) (
   input wire logic      clock,
   input wire logic      reset,
   bufuart_req_if.sink   req_if,
   bufuart_rsp_if.source rsp_if
);

   // command/status between the sequencer and the datapath
   bufuart_pkg::ctrl_cmd_type  cmd;
   bufuart_pkg::ctrl_stat_type stat;

   bufuart_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // pointers, counts and arming flags only move on a request transfer
   bufuart_dp #(
      .TX_DEPTH (TX_DEPTH),
      .RX_DEPTH (RX_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_type      (req_if.req_type),
      .tx_byte       (req_if.tx_byte),
      .line_byte     (req_if.line_byte),
      .framing_error (req_if.framing_error),
      .parity_error  (req_if.parity_error),
      .cmd           (cmd),
      .stat          (stat),
      .status        (rsp_if.status),
      .read_byte     (rsp_if.read_byte),
      .send_valid    (rsp_if.send_valid),
      .send_byte     (rsp_if.send_byte),
      .tx_full       (rsp_if.tx_full),
      .tx_empty      (rsp_if.tx_empty),
      .rx_empty      (rsp_if.rx_empty),
      .write_done    (rsp_if.write_done)
   );

endmodule

`default_nettype wire

[src/bufuart_checker.sv]
// Port-level assertions for the buffered UART channel, bound to the top level.
`default_nettype none

module bufuart_assertions (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [bufuart_pkg::STATUS_W-1:0] status,
   input wire logic [bufuart_pkg::DATA_W-1:0]   read_byte,
   input wire logic                             send_valid,
   input wire logic                             tx_full,
   input wire logic                             tx_empty,
   input wire logic                             write_done
);

   // no response right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(read_byte))
      else $error("stalled response changed");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && write_done |-> tx_empty)
      else $error("write_done with data in transmit FIFO");

   a_full_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(tx_full && tx_empty))
      else $error("transmit FIFO both full and empty");

   // a send is never paired with a read byte or a failing status
   a_send_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && send_valid |-> (status == bufuart_pkg::ST_OK) && (read_byte == '0))
      else $error("send with non-ok status or read byte");

endmodule

bind buffered_uart_channel bufuart_assertions u_bufuart_assertions (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .status     (rsp_if.status),
   .read_byte  (rsp_if.read_byte),
   .send_valid (rsp_if.send_valid),
   .tx_full    (rsp_if.tx_full),
   .tx_empty   (rsp_if.tx_empty),
   .write_done (rsp_if.write_done)
);

`default_nettype wire
